FILE: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CHECK = 2'd2
  } gha_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } gha_status_e;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_EXEC = 1'b1
  } gha_state_e;

  // Strobes of one memory port pair.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } gha_mem_ctl_t;

endpackage

FILE: rtl/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Hands out slot-index/version handles, frees them and checks them.
// ----------------------------------------------------------------------------
// Each transaction has an accept cycle, which launches reads of the slot
// memory (live bit and version per slot) and of the free stack top, and an
// execute state, which decides, writes both memories back and loads the
// result register. Both memories return registered read data.
// A finished result waits in the output register without blocking the next
// accept; a stalled result only holds the execute cycle. Allocate pops the
// most recently freed slot (its entry holds the version bumped at free time),
// otherwise takes the next fresh slot with version 1, otherwise reports pool
// full. Free of a valid handle bumps the version (wrapping), clears the live
// bit and pushes the slot. Slots never handed out are never trusted, so the
// memories need no clearing pass after reset.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int unsigned  MAX_SLOTS    = 1024,
  parameter int unsigned  VERSION_BITS = 16,
  localparam int unsigned IDX_W        = $clog2(MAX_SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FUNC_W-1:0]       func_i,
  input  logic [IDX_W-1:0]        req_index_i,
  input  logic [VERSION_BITS-1:0] req_version_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        out_index_o,
  output logic [VERSION_BITS-1:0] out_version_o,
  output logic [STATUS_W-1:0]     status_o
);

  localparam int unsigned VM_W  = VERSION_BITS + 1;
  localparam int unsigned STK_W = IDX_W + VERSION_BITS;

  gha_mem_ctl_t       vmem_ctl;
  logic [IDX_W-1:0]   vmem_raddr;
  logic [IDX_W-1:0]   vmem_waddr;
  logic [VM_W-1:0]    vmem_wdata;
  logic [VM_W-1:0]    vmem_rdata;
  gha_mem_ctl_t       stk_ctl;
  logic [IDX_W-1:0]   stk_raddr;
  logic [IDX_W-1:0]   stk_waddr;
  logic [STK_W-1:0]   stk_wdata;
  logic [STK_W-1:0]   stk_rdata;

  // Control: sequencer, counters, result register
  gha_ctrl #(
    .MAX_SLOTS    (MAX_SLOTS),
    .VERSION_BITS (VERSION_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .req_index_i   (req_index_i),
    .req_version_i (req_version_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_index_o   (out_index_o),
    .out_version_o (out_version_o),
    .status_o      (status_o),
    .vmem_ctl_o    (vmem_ctl),
    .vmem_raddr_o  (vmem_raddr),
    .vmem_waddr_o  (vmem_waddr),
    .vmem_wdata_o  (vmem_wdata),
    .vmem_rdata_i  (vmem_rdata),
    .stk_ctl_o     (stk_ctl),
    .stk_raddr_o   (stk_raddr),
    .stk_waddr_o   (stk_waddr),
    .stk_wdata_o   (stk_wdata),
    .stk_rdata_i   (stk_rdata)
  );

  // Slot memory: {live, version} per slot
  gha_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (VM_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .ctl_i   (vmem_ctl),
    .raddr_i (vmem_raddr),
    .waddr_i (vmem_waddr),
    .wdata_i (vmem_wdata),
    .rdata_o (vmem_rdata)
  );

  // Free stack: {slot, version} per entry, LIFO by the free count
  gha_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (STK_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .ctl_i   (stk_ctl),
    .raddr_i (stk_raddr),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  // Write-back never lands in an accept cycle, so reads never race writes.
  a_no_wr_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !vmem_ctl.wr_en && !stk_ctl.wr_en)
    else $error("memory write-back in an accept cycle");

  // One transaction in flight: no accept right after an accept.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accept while a transaction is in flight");

  // A stack push always comes with a slot write-back of the same slot.
  a_push_with_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctl.wr_en |-> vmem_ctl.wr_en && (stk_wdata[STK_W-1:VERSION_BITS] == vmem_waddr))
    else $error("free stack push without matching slot update");

  // Slot write-back, like a result load, happens only in the execute state.
  a_result_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vmem_ctl.wr_en) |-> !in_ready_o)
    else $error("slot write-back outside the execute cycle");

endmodule

FILE: rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Synchronous memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module gha_ram
  import gha_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  gha_mem_ctl_t       ctl_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [WIDTH-1:0]   wdata_i,
  output logic [WIDTH-1:0]   rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer, counters and result register: issues the memory reads at
// accept, then decides, writes back and loads the result.
// ----------------------------------------------------------------------------
module gha_ctrl
  import gha_pkg::*;
#(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16,
  parameter int unsigned IDX_W        = $clog2(MAX_SLOTS),
  parameter int unsigned CNT_W        = $clog2(MAX_SLOTS + 1),
  parameter int unsigned VM_W         = VERSION_BITS + 1,
  parameter int unsigned STK_W        = IDX_W + VERSION_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FUNC_W-1:0]       func_i,
  input  logic [IDX_W-1:0]        req_index_i,
  input  logic [VERSION_BITS-1:0] req_version_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        out_index_o,
  output logic [VERSION_BITS-1:0] out_version_o,
  output logic [STATUS_W-1:0]     status_o,
  output gha_mem_ctl_t            vmem_ctl_o,
  output logic [IDX_W-1:0]        vmem_raddr_o,
  output logic [IDX_W-1:0]        vmem_waddr_o,
  output logic [VM_W-1:0]         vmem_wdata_o,
  input  logic [VM_W-1:0]         vmem_rdata_i,
  output gha_mem_ctl_t            stk_ctl_o,
  output logic [IDX_W-1:0]        stk_raddr_o,
  output logic [IDX_W-1:0]        stk_waddr_o,
  output logic [STK_W-1:0]        stk_wdata_o,
  input  logic [STK_W-1:0]        stk_rdata_i
);

  gha_state_e state_q, state_d;

  logic [FUNC_W-1:0]       func_q;
  logic [IDX_W-1:0]        idx_q;
  logic [VERSION_BITS-1:0] ver_q;

  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] fresh_next_q, fresh_next_d;
  logic [CNT_W-1:0] free_count_dec;

  logic                    out_valid_q, out_valid_d;
  logic [IDX_W-1:0]        out_index_q, out_index_d;
  logic [VERSION_BITS-1:0] out_version_q, out_version_d;
  logic [STATUS_W-1:0]     status_q, status_d;

  logic                    accept;
  logic                    fire;
  logic                    vm_live;
  logic [VERSION_BITS-1:0] vm_ver;
  logic [VERSION_BITS-1:0] ver_inc;
  logic [IDX_W-1:0]        stk_idx;
  logic [VERSION_BITS-1:0] stk_ver;
  logic                    handle_ok;
  logic                    vm_wr;
  logic                    stk_wr;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      STATE_IDLE: if (in_valid_i) state_d = STATE_EXEC;
      STATE_EXEC: if (!out_valid_q || out_ready_i) state_d = STATE_IDLE;
      default:    state_d = STATE_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      STATE_IDLE: in_ready_o = 1'b1;
      STATE_EXEC: fire       = !out_valid_q || out_ready_i;
      default:    in_ready_o = 1'b0;
    endcase
  end

  assign accept         = in_valid_i && in_ready_o;
  assign free_count_dec = free_count_q - CNT_W'(1);

  // Reads go out with the transaction; data is ready in the execute cycle.
  assign vmem_raddr_o = req_index_i;
  assign stk_raddr_o  = free_count_dec[IDX_W-1:0];

  // Decide and write back
  always_comb begin
    vm_live   = vmem_rdata_i[VERSION_BITS];
    vm_ver    = vmem_rdata_i[VERSION_BITS-1:0];
    ver_inc   = vm_ver + VERSION_BITS'(1);
    stk_idx   = stk_rdata_i[STK_W-1:VERSION_BITS];
    stk_ver   = stk_rdata_i[VERSION_BITS-1:0];
    handle_ok = (CNT_W'(idx_q) < fresh_next_q) && vm_live && (vm_ver == ver_q);

    free_count_d  = free_count_q;
    fresh_next_d  = fresh_next_q;
    out_index_d   = idx_q;
    out_version_d = ver_q;
    status_d      = ST_INVALID;
    vm_wr         = 1'b0;
    stk_wr        = 1'b0;
    vmem_waddr_o  = idx_q;
    vmem_wdata_o  = {1'b0, ver_inc};
    stk_waddr_o   = free_count_q[IDX_W-1:0];
    stk_wdata_o   = {idx_q, ver_inc};

    unique case (func_q)
      FUNC_ALLOC: begin
        priority if (free_count_q != '0) begin
          // pop: the stack entry carries the version set at free time
          free_count_d  = free_count_dec;
          out_index_d   = stk_idx;
          out_version_d = stk_ver;
          status_d      = ST_OK;
          vm_wr         = 1'b1;
          vmem_waddr_o  = stk_idx;
          vmem_wdata_o  = {1'b1, stk_ver};
        end else if (fresh_next_q < CNT_W'(MAX_SLOTS)) begin
          fresh_next_d  = fresh_next_q + CNT_W'(1);
          out_index_d   = fresh_next_q[IDX_W-1:0];
          out_version_d = VERSION_BITS'(1);
          status_d      = ST_OK;
          vm_wr         = 1'b1;
          vmem_waddr_o  = fresh_next_q[IDX_W-1:0];
          vmem_wdata_o  = {1'b1, VERSION_BITS'(1)};
        end else begin
          status_d = ST_FULL;
        end
      end
      FUNC_FREE: begin
        if (handle_ok && (free_count_q < CNT_W'(MAX_SLOTS))) begin
          free_count_d = free_count_q + CNT_W'(1);
          status_d     = ST_OK;
          vm_wr        = 1'b1;
          stk_wr       = 1'b1;
        end
      end
      FUNC_CHECK: status_d = handle_ok ? ST_OK : ST_INVALID;
      default:    status_d = ST_INVALID;
    endcase
  end

  assign vmem_ctl_o = '{rd_en: accept, wr_en: fire && vm_wr};
  assign stk_ctl_o  = '{rd_en: accept, wr_en: fire && stk_wr};

  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= STATE_IDLE;
      free_count_q <= '0;
      fresh_next_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        free_count_q <= free_count_d;
        fresh_next_q <= fresh_next_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      idx_q  <= req_index_i;
      ver_q  <= req_version_i;
    end
    if (fire) begin
      out_index_q   <= out_index_d;
      out_version_q <= out_version_d;
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_version_o = out_version_q;
  assign status_o      = status_q;

endmodule

FILE: dv/generational_handle_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_top_tb
// Self-checking bench for the generational handle allocator: a directed table
// covers reset behavior, field extremes, every function code, double free,
// LIFO reuse and stale handles. Random traffic built from live and stale
// handles follows under three pacing profiles. Each result is compared
// against its typed table row or a cycle-free predictor of the allocator.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top_tb
  import gha_pkg::*;
();

  localparam int unsigned NUM_SLOTS    = 1024;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned VER_W        = 16;
  localparam int unsigned RANDOM_OPS   = 160;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  // Function code that the package leaves unassigned.
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VER_W-1:0] version;
    gha_status_e      status;
  } handle_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [VER_W-1:0]  version;
    logic              typed;
    handle_result_t    res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [IDX_W-1:0]    req_index_i;
  logic [VER_W-1:0]    req_version_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [IDX_W-1:0]    out_index_o;
  logic [VER_W-1:0]    out_version_o;
  logic [STATUS_W-1:0] status_o;

  // Idle percentages of the sender and the receiver.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count    = 0;

  // Allocator shadow state.
  logic [VER_W-1:0] slot_ver   [NUM_SLOTS];
  logic [IDX_W-1:0] free_lifo  [NUM_SLOTS];
  bit               slot_in_use[NUM_SLOTS];
  int unsigned      free_depth  = 0;
  int unsigned      fresh_count = 0;
  int unsigned      live_slots[$];

  handle_result_t pending_results[$];

  // Rows with typed = 1 carry a result readable straight from the spec; the
  // rest take their result from the predictor.
  dir_row_t dir_rows [24] = '{
    '{FUNC_CHECK,    10'd0,    16'd0,      1'b1, '{10'd0,    16'd0,      ST_INVALID}},
    '{FUNC_FREE,     10'd0,    16'd0,      1'b1, '{10'd0,    16'd0,      ST_INVALID}},
    '{FUNC_RESERVED, 10'd0,    16'd0,      1'b1, '{10'd0,    16'd0,      ST_INVALID}},
    '{FUNC_ALLOC,    10'd0,    16'd0,      1'b1, '{10'd0,    16'd1,      ST_OK}},
    '{FUNC_ALLOC,    10'd1023, 16'hFFFF,   1'b1, '{10'd1,    16'd1,      ST_OK}},
    '{FUNC_CHECK,    10'd0,    16'd1,      1'b1, '{10'd0,    16'd1,      ST_OK}},
    '{FUNC_CHECK,    10'd0,    16'd2,      1'b1, '{10'd0,    16'd2,      ST_INVALID}},
    '{FUNC_CHECK,    10'd1,    16'd0,      1'b1, '{10'd1,    16'd0,      ST_INVALID}},
    '{FUNC_CHECK,    10'd1023, 16'hFFFF,   1'b1, '{10'd1023, 16'hFFFF,   ST_INVALID}},
    '{FUNC_FREE,     10'd1023, 16'hFFFF,   1'b1, '{10'd1023, 16'hFFFF,   ST_INVALID}},
    '{FUNC_RESERVED, 10'd1023, 16'hFFFF,   1'b1, '{10'd1023, 16'hFFFF,   ST_INVALID}},
    '{FUNC_FREE,     10'd0,    16'd1,      1'b1, '{10'd0,    16'd1,      ST_OK}},
    '{FUNC_FREE,     10'd0,    16'd1,      1'b1, '{10'd0,    16'd1,      ST_INVALID}},
    '{FUNC_CHECK,    10'd0,    16'd1,      1'b0, '0},
    '{FUNC_CHECK,    10'd0,    16'd2,      1'b0, '0},
    '{FUNC_ALLOC,    10'd0,    16'd0,      1'b0, '0},
    '{FUNC_CHECK,    10'd0,    16'd2,      1'b0, '0},
    '{FUNC_FREE,     10'd1,    16'd1,      1'b0, '0},
    '{FUNC_FREE,     10'd0,    16'd2,      1'b0, '0},
    '{FUNC_ALLOC,    10'd555,  16'hAAAA,   1'b0, '0},
    '{FUNC_ALLOC,    10'd0,    16'h5555,   1'b0, '0},
    '{FUNC_ALLOC,    10'd0,    16'd0,      1'b0, '0},
    '{FUNC_CHECK,    10'd2,    16'd1,      1'b0, '0},
    '{FUNC_FREE,     10'd2,    16'd0,      1'b0, '0}
  };

  generational_handle_allocator_top #(
    .MAX_SLOTS   (NUM_SLOTS),
    .VERSION_BITS(VER_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .req_index_i  (req_index_i),
    .req_version_i(req_version_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_index_o  (out_index_o),
    .out_version_o(out_version_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // A handle is good only for a slot handed out before, in use now, and
  // carrying the current version.
  function automatic bit handle_is_live(input logic [IDX_W-1:0] idx,
                                        input logic [VER_W-1:0] ver);
    if (idx >= fresh_count) return 1'b0;
    if (!slot_in_use[idx]) return 1'b0;
    return slot_ver[idx] == ver;
  endfunction

  // Advance the shadow state by one transaction and return its result.
  task automatic apply_handle_op(input logic [FUNC_W-1:0] f,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [VER_W-1:0] ver,
                                 output handle_result_t r);
    int unsigned s;
    int          k;
    r.index   = idx;
    r.version = ver;
    r.status  = ST_INVALID;
    case (f)
      FUNC_ALLOC: begin
        if (free_depth > 0) begin
          // Pop the most recently freed slot; its version was bumped at free.
          free_depth--;
          s = free_lifo[free_depth];
        end else if (fresh_count < NUM_SLOTS) begin
          s = fresh_count;
          fresh_count++;
          slot_ver[s] = VER_W'(1);
        end else begin
          s = NUM_SLOTS;
        end
        if (s < NUM_SLOTS) begin
          slot_in_use[s] = 1'b1;
          live_slots     = {live_slots, s};
          r.index   = s[IDX_W-1:0];
          r.version = slot_ver[s];
          r.status  = ST_OK;
        end else begin
          r.status = ST_FULL;
        end
      end
      FUNC_FREE: begin
        if (handle_is_live(idx, ver)) begin
          slot_ver[idx]         = slot_ver[idx] + VER_W'(1);
          slot_in_use[idx]      = 1'b0;
          free_lifo[free_depth] = idx;
          free_depth++;
          // Search from the back: recently allocated slots sit there.
          for (k = live_slots.size() - 1; k >= 0; k--) begin
            if (live_slots[k] == idx) begin
              live_slots.delete(k);
              break;
            end
          end
          r.status = ST_OK;
        end
      end
      FUNC_CHECK: begin
        if (handle_is_live(idx, ver)) r.status = ST_OK;
      end
      default: begin
      end
    endcase
  endtask

  // Drive one transaction from a falling edge, hold it until accepted, then
  // record its expected result. Returns at the next falling edge.
  task automatic issue_op(input logic [FUNC_W-1:0] f,
                          input logic [IDX_W-1:0] idx,
                          input logic [VER_W-1:0] ver,
                          input bit use_typed,
                          input handle_result_t typed_res);
    handle_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    req_index_i   <= idx;
    req_version_i <= ver;
    do @(posedge clk_i); while (!in_ready_o);
    apply_handle_op(f, idx, ver, predicted);
    pending_results = {pending_results, (use_typed ? typed_res : predicted)};
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] f,
                         input logic [IDX_W-1:0] idx,
                         input logic [VER_W-1:0] ver);
    issue_op(f, idx, ver, 1'b0, '0);
  endtask

  // Mostly well-formed traffic: allocate, free and check live handles, poke
  // freed or stale versions, with some noise and reserved codes mixed in.
  task automatic random_op();
    int unsigned       pick;
    int unsigned       slot;
    logic [FUNC_W-1:0] f;
    pick = $urandom_range(99);
    if (pick < 30 || (pick < 70 && live_slots.size() == 0)) begin
      send_op(FUNC_ALLOC, IDX_W'($urandom), VER_W'($urandom));
    end else if (pick < 55) begin
      slot = live_slots[$urandom_range(live_slots.size() - 1)];
      send_op(FUNC_FREE, IDX_W'(slot), slot_ver[slot]);
    end else if (pick < 70) begin
      slot = live_slots[$urandom_range(live_slots.size() - 1)];
      send_op(FUNC_CHECK, IDX_W'(slot), slot_ver[slot]);
    end else if (pick < 80 && fresh_count > 0) begin
      // Current or previous version of a slot handed out before, live or not.
      slot = $urandom_range(fresh_count - 1);
      f = $urandom_range(1) ? FUNC_FREE : FUNC_CHECK;
      send_op(f, IDX_W'(slot), VER_W'(slot_ver[slot] - $urandom_range(1)));
    end else if (pick < 95) begin
      send_op(FUNC_W'($urandom_range(2)), IDX_W'($urandom), VER_W'($urandom));
    end else begin
      send_op(FUNC_RESERVED, IDX_W'($urandom), VER_W'($urandom));
    end
  endtask

  // Receiver: stall at random at every falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    handle_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result idx=%0d ver=%0d st=%0d with nothing pending",
                                out_index_o, out_version_o, status_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_index_o !== exp_res.index) begin
          note_mismatch($sformatf("out_index got %0d exp %0d", out_index_o, exp_res.index));
        end
        if (out_version_o !== exp_res.version) begin
          note_mismatch($sformatf("out_version got %0d exp %0d",
                                  out_version_o, exp_res.version));
        end
        if (status_o !== exp_res.status) begin
          note_mismatch($sformatf("status got %0d exp %0d", status_o, exp_res.status));
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_ALLOC;
    req_index_i   = '0;
    req_version_i = '0;
    src_idle_pct  = 33;
    sink_idle_pct = 62;

    // Hold reset, then release it at a falling edge.
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: slow receiver. Walk the directed table, then random traffic.
    foreach (dir_rows[i]) begin
      issue_op(dir_rows[i].func, dir_rows[i].index, dir_rows[i].version,
               dir_rows[i].typed, dir_rows[i].res);
    end
    repeat (RANDOM_OPS) random_op();

    // Phase 2: slow sender.
    src_idle_pct  = 62;
    sink_idle_pct = 33;
    repeat (RANDOM_OPS) random_op();

    // Phase 3: full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (RANDOM_OPS) random_op();

    // Drop valid and drain the outstanding results.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/gha_ctrl.sv
rtl/generational_handle_allocator_top.sv
dv/generational_handle_allocator_top_tb.sv
